FILE: rtl/core/mvm_pkg.sv
// Shared types and constants for the matrix-vector multiply unit.
// Used by mvm_mac and the top level under rtl/core; depends on nothing else.
package mvm_pkg;

  localparam int MAX_DIM_DEF   = 16;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W   = 32;
  localparam int ACC_W    = 48;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int IN_IDX_W = 4;
  localparam int SIZE_W   = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  localparam logic KIND_MATRIX = 1'b0;
  localparam logic KIND_VECTOR = 1'b1;

  // Control that travels alongside one multiply-accumulate step.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mvm_ctl_t;

endpackage

FILE: rtl/core/mvm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; no package needed.
module mvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/mvm_mac.sv
// Shared multiply-accumulate unit: registered multiply, then truncate,
// add and saturate into the row accumulator. Depends on mvm_pkg.
module mvm_mac #(
  parameter int FRAC_BITS = mvm_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mvm_pkg::mvm_ctl_t                ctl,
  input  logic signed [mvm_pkg::DATA_W-1:0] mat_data,
  input  logic signed [mvm_pkg::DATA_W-1:0] vec_data,
  output logic                             row_done,
  output logic signed [mvm_pkg::DATA_W-1:0] row_sum
);
  import mvm_pkg::*;

  localparam int SUM_W = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] ACC_MAX = (SUM_W'(1) <<< (ACC_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] ACC_MIN = -(SUM_W'(1) <<< (ACC_W - 1));
  localparam logic signed [ACC_W-1:0] OUT_MAX = (ACC_W'(1) <<< (DATA_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] OUT_MIN = -(ACC_W'(1) <<< (DATA_W - 1));

  mvm_ctl_t                  ctl_mul;
  mvm_ctl_t                  ctl_acc;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_trunc;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_base;
  logic signed [SUM_W-1:0]   sum;
  logic signed [ACC_W-1:0]   acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mul  <= '0;
      ctl_acc  <= '0;
      acc      <= '0;
      row_done <= 1'b0;
    end else begin
      ctl_mul  <= ctl;
      ctl_acc  <= ctl_mul;
      row_done <= ctl_acc.valid & ctl_acc.last;
      if (ctl_acc.valid) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mat_data) * PROD_W'(vec_data);
  end

  always_comb begin
    prod_trunc = prod >>> FRAC_BITS;
    acc_base   = ctl_acc.first ? '0 : acc;
    sum        = SUM_W'(acc_base) + SUM_W'(prod_trunc);
    if (sum > ACC_MAX) begin
      acc_next = ACC_MAX[ACC_W-1:0];
    end else if (sum < ACC_MIN) begin
      acc_next = ACC_MIN[ACC_W-1:0];
    end else begin
      acc_next = sum[ACC_W-1:0];
    end
  end

  always_comb begin
    if (acc > OUT_MAX) begin
      row_sum = OUT_MAX[DATA_W-1:0];
    end else if (acc < OUT_MIN) begin
      row_sum = OUT_MIN[DATA_W-1:0];
    end else begin
      row_sum = acc[DATA_W-1:0];
    end
  end

endmodule

FILE: rtl/core/matrix_vector_multiply_unit.sv
// Top level of the matrix-vector multiply unit: item decode, stores,
// row/column sequencer and result register. Uses mvm_pkg, mvm_ram, mvm_mac.
//
// Usage: each input item either writes one matrix element A[row][col] or one
// vector element x[col]. A vector item flagged vector_last writes its element
// and starts y = A*x over the leading n-by-n part, n being size_in_use
// clamped to 1..MAX_DIM. The unit then returns n result items in row order,
// the final one flagged out_last. Each row uses the single multiply-accumulate
// unit: one store read per column, each followed by multiply and accumulate,
// then a load of the result register. The input is not ready while a
// product runs. A stalled receiver holds the result register and pauses the
// sequencer before the next row is loaded; once the last result is loaded
// the input is ready again, even while that result still waits. Reset
// returns size_in_use to 16, clears the accumulator and drops both valids;
// store contents are kept but must be written before they are read. The
// user must write size_in_use only while idle; the block itself does not
// enforce it.
module matrix_vector_multiply_unit #(
  parameter int MAX_DIM   = mvm_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mvm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [mvm_pkg::SIZE_W-1:0]        cfg_write_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic [mvm_pkg::IN_IDX_W-1:0]      row_index,
  input  logic [mvm_pkg::IN_IDX_W-1:0]      col_index,
  input  logic signed [mvm_pkg::DATA_W-1:0] element_value,
  input  logic                              vector_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mvm_pkg::IN_IDX_W-1:0]      out_row,
  output logic signed [mvm_pkg::DATA_W-1:0] row_sum,
  output logic                              out_last
);
  import mvm_pkg::*;

  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int MDEPTH  = MAX_DIM * MAX_DIM;
  localparam int MADDR_W = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROW  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [SIZE_W-1:0]    size_in_use;
  logic [IDX_W-1:0]     last_idx;
  logic [IDX_W-1:0]     dim_last;
  logic [IDX_W-1:0]     row;
  logic [IDX_W-1:0]     col;
  logic [MADDR_W-1:0]   row_base;

  logic                 in_accept;
  logic                 row_ok;
  logic                 col_ok;
  logic                 mat_we;
  logic                 vec_we;
  logic                 start;
  logic [MADDR_W-1:0]   mat_waddr;
  logic [MADDR_W-1:0]   mat_raddr;
  logic [IDX_W-1:0]     vec_waddr;
  logic [DATA_W-1:0]    mat_rdata;
  logic [DATA_W-1:0]    vec_rdata;
  mvm_ctl_t             issue;
  logic                 row_done;
  logic signed [DATA_W-1:0] mac_sum;
  logic                 load_out;

  // Clamp the configured size to 1..MAX_DIM.
  always_comb begin
    if (size_in_use == '0) begin
      dim_last = '0;
    end else if (32'(size_in_use) > MAX_DIM) begin
      dim_last = IDX_W'(MAX_DIM - 1);
    end else begin
      dim_last = IDX_W'(32'(size_in_use) - 1);
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid & in_ready;
  assign row_ok    = (32'(row_index) < MAX_DIM);
  assign col_ok    = (32'(col_index) < MAX_DIM);
  assign mat_we    = in_accept & (kind == KIND_MATRIX) & row_ok & col_ok;
  assign vec_we    = in_accept & (kind == KIND_VECTOR) & col_ok;
  assign start     = in_accept & (kind == KIND_VECTOR) & vector_last;
  assign mat_waddr = MADDR_W'(32'(row_index) * MAX_DIM + 32'(col_index));
  assign vec_waddr = IDX_W'(col_index);
  assign mat_raddr = MADDR_W'(row_base + MADDR_W'(col));
  assign load_out  = (state == ST_EMIT) & (~out_valid | out_ready);

  always_comb begin
    issue.valid = (state == ST_ROW);
    issue.first = (col == '0);
    issue.last  = (col == last_idx);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_ROW;
        end
      end
      ST_ROW: begin
        if (col == last_idx) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (row_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          state_next = (row == last_idx) ? ST_IDLE : ST_ROW;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      size_in_use <= SIZE_RESET;
      out_valid   <= 1'b0;
      row         <= '0;
      col         <= '0;
      row_base    <= '0;
      last_idx    <= '0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        size_in_use <= cfg_write_data;
      end
      if (start) begin
        last_idx <= dim_last;
        row      <= '0;
        col      <= '0;
        row_base <= '0;
      end
      if (state == ST_ROW) begin
        col <= (col == last_idx) ? '0 : col + IDX_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
        row       <= row + IDX_W'(1);
        row_base  <= MADDR_W'(32'(row_base) + MAX_DIM);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_row  <= IN_IDX_W'(row);
      row_sum  <= mac_sum;
      out_last <= (row == last_idx);
    end
  end

  mvm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MDEPTH)
  ) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (element_value),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  mvm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_DIM)
  ) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (element_value),
    .raddr (col),
    .rdata (vec_rdata)
  );

  mvm_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (issue),
    .mat_data (signed'(mat_rdata)),
    .vec_data (signed'(vec_rdata)),
    .row_done (row_done),
    .row_sum  (mac_sum)
  );

endmodule
